// File: hw/rtl/multipath_tapped_delay_mix_top_defines.svh
// assertion macros for the multipath tapped delay mixer
`ifndef MULTIPATH_TAPPED_DELAY_MIX_TOP_DEFINES_SVH
`define MULTIPATH_TAPPED_DELAY_MIX_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MTDM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mtdm same-cycle check failed");

// next-cycle implication, checked out of reset
`define MTDM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mtdm next-cycle check failed");

`endif

// File: hw/rtl/mtdm_pkg.sv
// shared types and constants for the multipath tapped delay mixer
package mtdm_pkg;

    localparam int MAX_DELAY  = 1024;
    localparam int MAX_PATHS  = 4;
    localparam int SAMPLE_W   = 16;

    localparam int ADDR_W     = $clog2(MAX_DELAY);
    localparam int SEEN_W     = ADDR_W + 1;
    localparam int PATH_W     = $clog2(MAX_PATHS);
    localparam int COUNT_W    = 3;
    localparam int DELAY_W    = 10;
    localparam int GAIN_W     = 16;
    localparam int WORD_W     = DELAY_W + GAIN_W;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = SAMPLE_W + GAIN_W;
    localparam int ACC_W      = PROD_W + PATH_W;
    localparam int FRAC_W     = 15;
    localparam int SHIFTED_W  = ACC_W - FRAC_W;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_PATH_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATH_WORD_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATH_WORD_3 = 3'd4;

    typedef logic [WORD_W-1:0] path_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_MUL,
        ST_ACC,
        ST_ROUND
    } mtdm_state_t;

endpackage

// File: hw/rtl/multipath_tapped_delay_mix_top.sv
// Multipath tapped delay mixer: each input beat writes one Q1.15 sample into a 1024-entry
// history memory, then a small sequencer walks all four path slots with one shared
// 16x16 multiplier and one history read port: per path an address state reads the memory,
// a multiply state forms the product and an accumulate state adds it. A slot beyond
// path_count, or whose delay reaches back past the block start, adds nothing. A final
// round state rounds and saturates into the output register, waiting while that register
// still holds an unclaimed result; s_ready is low while an item is in work. The result waits
// in its own register, so the next sample can be taken while it is still unclaimed.
// The config port is always ready and should be written only while the block is idle.
`include "multipath_tapped_delay_mix_top_defines.svh"

module multipath_tapped_delay_mix_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [mtdm_pkg::SAMPLE_W-1:0] s_in_sample,
    input  logic                                s_first_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mtdm_pkg::SAMPLE_W-1:0] m_out_sample,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mtdm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mtdm_pkg::WORD_W-1:0]         cfg_data
);
    import mtdm_pkg::*;

    mtdm_state_t state_reg, state_next;

    logic [COUNT_W-1:0]        path_count_reg;
    path_word_t                path_word_reg [MAX_PATHS];

    logic [SAMPLE_W-1:0]       hist_mem [MAX_DELAY];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    logic [ADDR_W-1:0]         wp_reg;
    logic [ADDR_W-1:0]         base_reg;
    logic [SEEN_W-1:0]         seen_reg;
    logic [SEEN_W-1:0]         seen_before_reg;
    logic [PATH_W-1:0]         path_reg;
    logic                      tap_ok_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [SAMPLE_W-1:0] out_reg;
    logic                      out_valid_reg;

    logic                      in_fire;
    logic                      out_load;
    logic                      last_path;
    logic [SEEN_W-1:0]         seen_base;
    logic [SEEN_W-1:0]         seen_next;
    logic [COUNT_W-1:0]        n_paths;
    logic [DELAY_W-1:0]        cur_delay;
    logic signed [GAIN_W-1:0]  cur_gain;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      tap_ok;
    logic signed [ACC_W-1:0]   rsum;
    logic signed [SHIFTED_W-1:0] shifted;
    logic signed [SAMPLE_W-1:0] sat_val;

    localparam logic signed [SHIFTED_W-1:0] SAT_HI =
        SHIFTED_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [SHIFTED_W-1:0] SAT_LO = -SAT_HI - SHIFTED_W'(1);
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1 << (FRAC_W - 1));

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = out_valid_reg;
    assign m_out_sample = out_reg;
    assign in_fire      = s_valid && s_ready;
    assign last_path    = (path_reg == PATH_W'(MAX_PATHS - 1));

    // block start clears the count, which saturates at the store depth
    assign seen_base = s_first_sample ? '0 : seen_reg;
    assign seen_next = (seen_base == SEEN_W'(MAX_DELAY)) ? seen_base
                                                         : seen_base + SEEN_W'(1);

    assign n_paths   = (path_count_reg > COUNT_W'(MAX_PATHS)) ? COUNT_W'(MAX_PATHS)
                                                              : path_count_reg;
    assign cur_delay = path_word_reg[path_reg][WORD_W-1:GAIN_W];
    assign cur_gain  = path_word_reg[path_reg][GAIN_W-1:0];
    assign rd_addr   = base_reg - ADDR_W'(cur_delay);
    assign tap_ok    = (COUNT_W'(path_reg) < n_paths) &&
                       (SEEN_W'(cur_delay) <= seen_before_reg);

    // round half up, then clamp
    assign rsum    = acc_reg + HALF_LSB;
    assign shifted = SHIFTED_W'(rsum >>> FRAC_W);
    assign sat_val = (shifted > SAT_HI) ? SAMPLE_W'(SAT_HI) :
                     (shifted < SAT_LO) ? SAMPLE_W'(SAT_LO) : SAMPLE_W'(shifted);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                state_next = last_path ? ST_ROUND : ST_ADDR;
            end
            ST_ROUND: begin
                // hold until the output register is free
                if (!out_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            path_count_reg <= '0;
            for (int i = 0; i < MAX_PATHS; i++) begin
                path_word_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_PATH_COUNT) begin
                path_count_reg <= cfg_data[COUNT_W-1:0];
            end else if (cfg_index >= REG_PATH_WORD_0 && cfg_index <= REG_PATH_WORD_3) begin
                path_word_reg[PATH_W'(cfg_index - REG_PATH_WORD_0)] <= cfg_data;
            end
        end
    end

    // history memory: write on accept, registered read per path
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            hist_mem[wp_reg] <= s_in_sample;
        end
        if (state_reg == ST_ADDR) begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    // position and block counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            seen_reg <= '0;
        end else if (in_fire) begin
            wp_reg   <= wp_reg + ADDR_W'(1);
            seen_reg <= seen_next;
        end
    end

    // per-item datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            path_reg <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        base_reg        <= wp_reg;
                        seen_before_reg <= seen_base;
                        acc_reg         <= '0;
                        path_reg        <= '0;
                    end
                end
                ST_ADDR: begin
                    tap_ok_reg <= tap_ok;
                end
                ST_MUL: begin
                    prod_reg <= rd_data_reg * cur_gain;
                end
                ST_ACC: begin
                    if (tap_ok_reg) begin
                        acc_reg <= acc_reg + ACC_W'(prod_reg);
                    end
                    path_reg <= path_reg + PATH_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
            out_reg       <= sat_val;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    `MTDM_ASSERT_NEXT(a_accept_starts_walk, in_fire, (state_reg == ST_ADDR) && (path_reg == '0))
    `MTDM_ASSERT_NOW(a_seen_bounded, 1'b1, seen_reg <= SEEN_W'(MAX_DELAY))
    `MTDM_ASSERT_NEXT(a_last_path_rounds, (state_reg == ST_ACC) && last_path, state_reg == ST_ROUND)
    `MTDM_ASSERT_NEXT(a_acc_only_in_acc, (state_reg == ST_ADDR) || (state_reg == ST_MUL), $stable(acc_reg))
    `MTDM_ASSERT_NEXT(a_load_sets_valid, out_load, out_valid_reg && (state_reg == ST_IDLE))

endmodule

// File: sim/multipath_tapped_delay_mix_top_test.sv
// self-checking bench for the multipath tapped delay mixer
module multipath_tapped_delay_mix_top_test;
    import mtdm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_PATH_WORD_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATH_WORD_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_5     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7     = 3'd7;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_TICKS = 40;
    localparam int LONG_BLOCK   = 180;

    class mix_scoreboard;
        logic [COUNT_W-1:0]         path_count = '0;
        logic [WORD_W-1:0]          path_word [MAX_PATHS] = '{default: '0};
        logic signed [SAMPLE_W-1:0] history [MAX_DELAY];
        logic [ADDR_W-1:0]          wr_pos = '0;
        int unsigned                seen = 0;
        logic signed [SAMPLE_W-1:0] expected_out [$];
        int                         mismatch_count = 0;
        int                         out_beats = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
            if (idx == REG_PATH_COUNT)
                path_count = data[COUNT_W-1:0];
            else if (idx >= REG_PATH_WORD_0 && idx <= REG_PATH_WORD_3)
                path_word[idx - REG_PATH_WORD_0] = data;
        endfunction

        // stores the sample and queues the mixed output it produces
        function void mix_sample(logic signed [SAMPLE_W-1:0] smp, logic first_flag);
            int unsigned n_paths;
            int unsigned delay;
            int unsigned seen_before;
            logic [ADDR_W-1:0] rd_pos;
            logic signed [GAIN_W-1:0] gain;
            longint acc;
            longint res;
            longint hi;
            acc = 0;
            hi = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
            if (first_flag)
                seen = 0;
            seen_before = seen;
            history[wr_pos] = smp;
            n_paths = (path_count > MAX_PATHS) ? MAX_PATHS : path_count;
            for (int p = 0; p < n_paths; p++) begin
                delay = path_word[p][WORD_W-1:GAIN_W];
                gain = path_word[p][GAIN_W-1:0];
                // taps reaching back past the block start add nothing
                if (delay <= seen_before) begin
                    rd_pos = wr_pos - ADDR_W'(delay);
                    acc += longint'(history[rd_pos]) * longint'(gain);
                end
            end
            wr_pos++;
            if (seen < MAX_DELAY)
                seen++;
            // add one half, then floor
            res = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
            if (res > hi)
                res = hi;
            if (res < -hi - 1)
                res = -hi - 1;
            expected_out.push_back(SAMPLE_W'(res));
        endfunction

        task report_mismatch(string msg);
            mismatch_count++;
            if (mismatch_count <= 100)
                $display("mismatch: %s", msg);
        endtask

        task check_out_sample(logic signed [SAMPLE_W-1:0] got);
            logic signed [SAMPLE_W-1:0] want;
            out_beats++;
            if (expected_out.size() == 0) begin
                report_mismatch($sformatf("out beat %0d with no sample pending, got %0d",
                                          out_beats, got));
                return;
            end
            want = expected_out.pop_front();
            if (got !== want)
                report_mismatch($sformatf("out beat %0d out_sample got %0d expected %0d",
                                          out_beats, got, want));
        endtask
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_in_sample;
    logic                       s_first_sample;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_out_sample;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [WORD_W-1:0]          cfg_data;

    mix_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;

    multipath_tapped_delay_mix_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_sample    (s_in_sample),
        .s_first_sample (s_first_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_sample   (m_out_sample),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                sb.mix_sample(s_in_sample, s_first_sample);
            if (m_valid && m_ready)
                sb.check_out_sample(m_out_sample);
        end
    end

    // mostly plain values, with full-scale and zero patterns mixed in
    function automatic logic [SAMPLE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_item(input logic signed [SAMPLE_W-1:0] smp, input logic first_flag);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_in_sample    <= smp;
        s_first_sample <= first_flag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // hold off the sender until every queued output has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_out.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic random_config();
        logic [WORD_W-1:0] w;
        w = WORD_W'($urandom);
        w[COUNT_W-1:0] = COUNT_W'($urandom_range(0, 7));
        cfg_write(REG_PATH_COUNT, w);
        for (int p = 0; p < MAX_PATHS; p++) begin
            w[GAIN_W-1:0] = pick_value();
            if ($urandom_range(0, 7) == 0)
                w[WORD_W-1:GAIN_W] = DELAY_W'($urandom_range(0, MAX_DELAY - 1));
            else
                w[WORD_W-1:GAIN_W] = DELAY_W'($urandom_range(0, 12));
            cfg_write(REG_PATH_WORD_0 + CFG_IDX_W'(p), w);
        end
    endtask

    task automatic run_random(input int n_items);
        for (int i = 0; i < n_items; i++)
            send_item(pick_value(), $urandom_range(0, 39) == 0);
    endtask

    initial begin
        int send_mix [4];
        int recv_mix [4];
        send_mix = '{0, 46, 0, 15};
        recv_mix = '{0, 0, 46, 15};
        sb = new();
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_in_sample    = '0;
        s_first_sample = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // no paths in use after reset: silence
        send_item(16'h7FFF, 1'b1);
        send_item(16'h8000, 1'b0);
        drain();

        // single half-scale path exercises rounding ties both signs
        cfg_write(REG_PATH_COUNT, WORD_W'(1));
        cfg_write(REG_PATH_WORD_0, {10'd0, 16'h4000});
        cfg_write(REG_SPARE_5, '1);
        cfg_write(REG_SPARE_6, '1);
        cfg_write(REG_SPARE_7, '1);
        send_item(16'sd1, 1'b1);
        send_item(-16'sd1, 1'b0);
        send_item(16'sd3, 1'b0);
        send_item(-16'sd3, 1'b0);
        drain();

        // count above four still uses four paths, full-scale sums saturate
        cfg_write(REG_PATH_COUNT, WORD_W'(7));
        for (int p = 0; p < MAX_PATHS; p++)
            cfg_write(REG_PATH_WORD_0 + CFG_IDX_W'(p), {10'd0, 16'h7FFF});
        send_item(16'h7FFF, 1'b1);
        send_item(16'h8000, 1'b0);
        drain();

        // staggered taps switch on one by one after the block start
        for (int p = 0; p < MAX_PATHS; p++)
            cfg_write(REG_PATH_WORD_0 + CFG_IDX_W'(p), {DELAY_W'(p), 16'h8000});
        send_item(16'h8000, 1'b1);
        repeat (3) send_item(16'h8000, 1'b0);
        drain();

        cfg_write(REG_PATH_COUNT, WORD_W'(4));
        cfg_write(REG_PATH_WORD_0, {10'd1023, 16'h7FFF});
        cfg_write(REG_PATH_WORD_1, {10'd1, 16'h8000});
        cfg_write(REG_PATH_WORD_2, {10'd2, 16'h1234});
        cfg_write(REG_PATH_WORD_3, {10'd0, 16'hC000});
        send_item(16'sd100, 1'b1);
        send_item(16'sd200, 1'b0);
        send_item(16'sd300, 1'b0);
        send_item(16'sd400, 1'b1);
        send_item(16'sd500, 1'b0);
        send_item(16'h7FFF, 1'b0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_mix[ph];
            recv_stall_pct = recv_mix[ph];
            repeat (2) begin
                random_config();
                run_random(25);
                drain();
            end
        end

        // one longer block so a deep tap comes into range; the 1023 tap stays out of it
        send_idle_pct  = 15;
        recv_stall_pct = 15;
        cfg_write(REG_PATH_COUNT, WORD_W'(4));
        cfg_write(REG_PATH_WORD_0, {10'd1023, pick_value()});
        cfg_write(REG_PATH_WORD_1, {DELAY_W'($urandom_range(100, 170)), pick_value()});
        cfg_write(REG_PATH_WORD_2, {10'd1, pick_value()});
        cfg_write(REG_PATH_WORD_3, {10'd0, pick_value()});
        send_item(pick_value(), 1'b1);
        repeat (LONG_BLOCK - 1) send_item(pick_value(), 1'b0);
        drain();

        repeat (SETTLE_TICKS) @(negedge aclk);
        if (sb.mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/mtdm_pkg.sv
hw/rtl/multipath_tapped_delay_mix_top.sv
sim/multipath_tapped_delay_mix_top_test.sv
